// ===== src/scoped_symbol_table_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the scoped symbol table.
// Same-cycle and next-cycle implication checks under a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef SCOPED_SYMBOL_TABLE_MACROS_SVH
`define SCOPED_SYMBOL_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sst_pkg.sv =====
// ---------------------------------------------------------------------------
// Scoped symbol table package
// Sizes, operation and status codes, and the transaction and memory types.
// ---------------------------------------------------------------------------
package sst_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int RES_IDX_W   = 6;

  // Operation codes
  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_SEARCH    = 3'd1;
  localparam logic [2:0] OP_FILL_TYPE = 3'd2;
  localparam logic [2:0] OP_FILL_CAT  = 3'd3;
  localparam logic [2:0] OP_READ      = 3'd4;

  // Status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_EXISTS    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NO_NAME   = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_DONE      = 3'd6;
  localparam logic [2:0] ST_BAD_INDEX = 3'd7;

  localparam logic [7:0] EMPTY_MARK = 8'hFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] name_key;
    logic        name_present;
    logic [7:0]  token_kind;
    logic [7:0]  scope_level;
    logic [7:0]  fill_value;
    logic [7:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [RES_IDX_W-1:0] result_index;
    logic [15:0]          out_name_key;
    logic [7:0]           out_token_kind;
    logic [7:0]           out_scope;
    logic [7:0]           out_type;
    logic [7:0]           out_category;
    logic [RES_IDX_W-1:0] last_index;
  } out_item_t;

  // Write port of the entry memories
  typedef struct packed {
    logic             ent_we;
    logic             type_we;
    logic             cat_we;
    logic [IDX_W-1:0] addr;
    logic [15:0]      name;
    logic [7:0]       kind;
    logic [7:0]       scope;
    logic [7:0]       value;
  } sst_wr_t;

  // One stored entry as read back
  typedef struct packed {
    logic [15:0] name;
    logic [7:0]  kind;
    logic [7:0]  scope;
    logic [7:0]  dtype;
    logic [7:0]  category;
  } sst_entry_t;

endpackage

// ===== src/scoped_symbol_table.sv =====
// The block holds one transaction at a time: in_ready is high only in the idle state,
// and a new one is accepted only after the result register has taken the last result.
// The entry walk through the shared compare unit and single-port read memory visits
// one entry per cycle.
// Reset: rst_n synchronous active low empties the table and clears the last index;
// entry memories are not cleared.
// ---------------------------------------------------------------------------
// Scoped symbol table
// Append-only symbol table with insert, search, back-fill and read, and a
// result register that holds one finished transaction for the consumer.
// ---------------------------------------------------------------------------
module scoped_symbol_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sst_pkg::out_item_t out_data
);

  logic                      res_valid;
  logic                      res_ready;
  sst_pkg::out_item_t        res_data;
  sst_pkg::sst_wr_t          mem_wr;
  logic [sst_pkg::IDX_W-1:0] rd_addr;
  sst_pkg::sst_entry_t       rd_entry;

  logic                      out_valid_r;
  sst_pkg::out_item_t        out_data_r;

  sst_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_wr    (mem_wr),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry)
  );

  sst_mem u_mem (
    .clk      (clk),
    .wr       (mem_wr),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // Load the result register when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/sst_mem.sv =====
// ---------------------------------------------------------------------------
// Scoped symbol table entry memories
// One write port and one registered read port shared by all entry fields.
// ---------------------------------------------------------------------------
module sst_mem (
  input  logic                    clk,
  input  sst_pkg::sst_wr_t        wr,
  input  logic [sst_pkg::IDX_W-1:0] rd_addr,
  output sst_pkg::sst_entry_t     rd_entry
);

  logic [15:0] names_mem [sst_pkg::TABLE_DEPTH];
  logic [7:0]  kinds_mem [sst_pkg::TABLE_DEPTH];
  logic [7:0]  scopes_mem[sst_pkg::TABLE_DEPTH];
  logic [7:0]  types_mem [sst_pkg::TABLE_DEPTH];
  logic [7:0]  cats_mem  [sst_pkg::TABLE_DEPTH];

  sst_pkg::sst_entry_t rd_entry_r;

  // Write the appended entry or the back-filled field
  always_ff @(posedge clk) begin
    if (wr.ent_we) begin
      names_mem[wr.addr]  <= wr.name;
      kinds_mem[wr.addr]  <= wr.kind;
      scopes_mem[wr.addr] <= wr.scope;
    end
    if (wr.type_we) begin
      types_mem[wr.addr] <= wr.value;
    end
    if (wr.cat_we) begin
      cats_mem[wr.addr] <= wr.value;
    end
  end

  // Read every cycle into the output register
  always_ff @(posedge clk) begin
    rd_entry_r.name     <= names_mem[rd_addr];
    rd_entry_r.kind     <= kinds_mem[rd_addr];
    rd_entry_r.scope    <= scopes_mem[rd_addr];
    rd_entry_r.dtype    <= types_mem[rd_addr];
    rd_entry_r.category <= cats_mem[rd_addr];
  end

  assign rd_entry = rd_entry_r;

endmodule

// ===== src/sst_seq.sv =====
// ---------------------------------------------------------------------------
// Scoped symbol table sequencer
// Walks the table one entry per cycle with a single key compare and zero
// check, appends entries, and builds one result per transaction.
// ---------------------------------------------------------------------------
`include "scoped_symbol_table_macros.svh"

module sst_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sst_pkg::in_item_t         in_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output sst_pkg::out_item_t        res_data,
  output sst_pkg::sst_wr_t          mem_wr,
  output logic [sst_pkg::IDX_W-1:0] rd_addr,
  input  sst_pkg::sst_entry_t       rd_entry
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_RD1   = 3'd4;
  localparam logic [2:0] S_RD2   = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  localparam int IW = sst_pkg::IDX_W;
  localparam int CW = sst_pkg::CNT_W;
  localparam int RW = sst_pkg::RES_IDX_W;

  logic [2:0]          state_r, state_nxt;
  sst_pkg::in_item_t   item_r, item_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       last_hit_r, last_hit_nxt;
  logic [IW-1:0]       addr_r, addr_nxt;
  logic                pend_r, pend_nxt;
  logic [IW-1:0]       pend_addr_r, pend_addr_nxt;
  sst_pkg::out_item_t  res_r, res_nxt;

  logic                full;
  logic [IW-1:0]       count_last;
  logic                match;
  logic [7:0]          fill_field;
  logic                do_insert;
  logic                take_hit;

  // Shared compare unit: key and scope match, field zero check
  assign full       = (count_r == CW'(sst_pkg::TABLE_DEPTH));
  assign count_last = IW'(count_r - CW'(1));
  assign match      = pend_r && (rd_entry.name == item_r.name_key) &&
                      (rd_entry.scope == item_r.scope_level);
  assign fill_field = (item_r.op == sst_pkg::OP_FILL_TYPE) ? rd_entry.dtype
                                                           : rd_entry.category;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign rd_addr   = addr_r;

  always_comb begin
    res_data            = res_r;
    res_data.last_index = RW'(last_hit_r);
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    last_hit_nxt  = last_hit_r;
    addr_nxt      = addr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    res_nxt       = res_r;
    mem_wr        = '0;
    do_insert     = 1'b0;
    take_hit      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_START;
        end
      end

      S_START: begin
        res_nxt        = '0;
        res_nxt.status = sst_pkg::ST_DONE;
        pend_nxt       = 1'b0;
        case (item_r.op)
          sst_pkg::OP_INSERT: begin
            if (full) begin
              res_nxt.status = sst_pkg::ST_FULL;
              state_nxt      = S_RESP;
            end else if (!item_r.name_present) begin
              res_nxt.status = sst_pkg::ST_NO_NAME;
              state_nxt      = S_RESP;
            end else if (count_r == '0) begin
              do_insert = 1'b1;
            end else begin
              addr_nxt  = count_last;
              state_nxt = S_SCAN;
            end
          end
          sst_pkg::OP_SEARCH: begin
            if (count_r == '0) begin
              res_nxt.status = sst_pkg::ST_NOT_FOUND;
              state_nxt      = S_RESP;
            end else begin
              addr_nxt  = count_last;
              state_nxt = S_SCAN;
            end
          end
          sst_pkg::OP_FILL_TYPE, sst_pkg::OP_FILL_CAT: begin
            if (count_r == '0) begin
              state_nxt = S_RESP;
            end else begin
              addr_nxt  = count_last;
              state_nxt = S_FILL;
            end
          end
          sst_pkg::OP_READ: begin
            if (32'(item_r.entry_index) < 32'(count_r)) begin
              addr_nxt  = IW'(item_r.entry_index);
              state_nxt = S_RD1;
            end else begin
              res_nxt.status         = sst_pkg::ST_BAD_INDEX;
              res_nxt.out_token_kind = sst_pkg::EMPTY_MARK;
              state_nxt              = S_RESP;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      // Walk downward so the first match is the highest index
      S_SCAN: begin
        pend_nxt      = 1'b1;
        pend_addr_nxt = addr_r;
        addr_nxt      = addr_r - 1'b1;
        if (match) begin
          take_hit = 1'b1;
        end else if (pend_r && (pend_addr_r == '0)) begin
          if (item_r.op == sst_pkg::OP_INSERT) begin
            do_insert = 1'b1;
          end else begin
            res_nxt.status = sst_pkg::ST_NOT_FOUND;
            state_nxt      = S_RESP;
          end
        end
      end

      // Back-fill the trailing unknown run, stop at the first known entry
      S_FILL: begin
        pend_nxt      = 1'b1;
        pend_addr_nxt = addr_r;
        addr_nxt      = addr_r - 1'b1;
        if (pend_r) begin
          if (fill_field == 8'd0) begin
            mem_wr.addr    = pend_addr_r;
            mem_wr.value   = item_r.fill_value;
            mem_wr.type_we = (item_r.op == sst_pkg::OP_FILL_TYPE);
            mem_wr.cat_we  = (item_r.op == sst_pkg::OP_FILL_CAT);
            if (pend_addr_r == '0) begin
              state_nxt = S_RESP;
            end
          end else begin
            state_nxt = S_RESP;
          end
        end
      end

      S_RD1: begin
        state_nxt = S_RD2;
      end

      S_RD2: begin
        res_nxt.result_index   = RW'(item_r.entry_index);
        res_nxt.out_name_key   = rd_entry.name;
        res_nxt.out_token_kind = rd_entry.kind;
        res_nxt.out_scope      = rd_entry.scope;
        res_nxt.out_type       = rd_entry.dtype;
        res_nxt.out_category   = rd_entry.category;
        state_nxt              = S_RESP;
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Append a new entry with unknown type and category
    if (do_insert) begin
      mem_wr.ent_we        = 1'b1;
      mem_wr.type_we       = 1'b1;
      mem_wr.cat_we        = 1'b1;
      mem_wr.addr          = IW'(count_r);
      mem_wr.name          = item_r.name_key;
      mem_wr.kind          = item_r.token_kind;
      mem_wr.scope         = item_r.scope_level;
      mem_wr.value         = 8'd0;
      last_hit_nxt         = IW'(count_r);
      count_nxt            = count_r + CW'(1);
      res_nxt.status       = sst_pkg::ST_INSERTED;
      res_nxt.result_index = RW'(count_r);
      state_nxt            = S_RESP;
    end

    // Report an existing or found entry
    if (take_hit) begin
      last_hit_nxt         = pend_addr_r;
      res_nxt.status       = (item_r.op == sst_pkg::OP_INSERT) ? sst_pkg::ST_EXISTS
                                                               : sst_pkg::ST_FOUND;
      res_nxt.result_index = RW'(pend_addr_r);
      state_nxt            = S_RESP;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      last_hit_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      last_hit_r <= last_hit_nxt;
      pend_r     <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    addr_r      <= addr_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_r       <= res_nxt;
  end

  `SST_ASSERT_NOW(a_insert_not_full, clk, rst_n, mem_wr.ent_we,
    32'(count_r) < sst_pkg::TABLE_DEPTH, "entry appended to a full table")
  `SST_ASSERT_NEXT(a_count_advance, clk, rst_n, mem_wr.ent_we,
    count_r == $past(count_r) + CW'(1), "entry count did not advance on append")
  `SST_ASSERT_NOW(a_fill_in_range, clk, rst_n, mem_wr.type_we && !mem_wr.ent_we,
    32'(mem_wr.addr) < 32'(count_r), "back-fill outside the filled entries")
  `SST_ASSERT_NEXT(a_count_hold, clk, rst_n, !mem_wr.ent_we,
    count_r == $past(count_r), "entry count changed without an append")

endmodule
